// ===== hdl/telemetry_frame_builder_core_defines.svh =====
// Assertion macros shared by the telemetry frame builder RTL.
// Expects signals named clock and reset in the including module.
`ifndef TELEMETRY_FRAME_BUILDER_CORE_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TFB_ASSERT_IMPL(LABEL, ANTE, CONS) \
   LABEL: assert property (@(posedge clock) disable iff (reset) (ANTE) |-> (CONS)) \
      else $error("tfb: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define TFB_ASSERT_NEXT(LABEL, ANTE, CONS) \
   LABEL: assert property (@(posedge clock) disable iff (reset) (ANTE) |=> (CONS)) \
      else $error("tfb: next-cycle check failed");

`endif

// ===== hdl/tfb_pkg.sv =====
// Types and constants for the telemetry frame builder.
// No dependencies; used by telemetry_frame_builder_core.
`default_nettype none

package tfb_pkg;

   localparam int unsigned FrameLen = 24;
   localparam logic [4:0]  LastPos  = 5'(FrameLen - 1);

   localparam logic [7:0] MagicA       = 8'hA5;
   localparam logic [7:0] MagicB       = 8'h5A;
   localparam logic [7:0] UnitTempBit  = 8'h01;
   localparam logic [7:0] UnitPressBit = 8'h02;

   // Fahrenheit conversion: divide by five through a reciprocal multiply.
   localparam logic [31:0] FahrOffset = 32'd3200;
   localparam int unsigned FifthShift = 22;
   localparam logic [19:0] FifthRecip = 20'd838861;

   // Inches of mercury: (pa * 100000 + bias) / divisor via a 2^56 reciprocal.
   localparam logic [33:0] PaScale     = 34'd100000;
   localparam logic [33:0] InhgBias    = 34'd1693194;
   localparam logic [63:0] InhgDivisor = 64'd3386389;
   localparam int unsigned InhgShift   = 56;
   localparam logic [34:0] InhgRecip   =
      35'(((64'd1 << InhgShift) + InhgDivisor - 64'd1) / InhgDivisor);

   typedef enum logic [0:0] {
      REG_TEMP_F     = 1'b0,
      REG_PRESS_INHG = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        sequence_number;
      logic [31:0]        timestamp;
      logic signed [15:0] temperature_c100;
      logic [31:0]        humidity;
      logic [16:0]        pressure_pa;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [4:0] byte_position;
      logic       last_byte;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/telemetry_frame_builder_core.sv =====
// Telemetry frame builder: one reading in, a 24-byte XOR-checked frame out.
// A reading passes stages 1 to 3, then loads the shifter that presents its bytes.
// The output shifter gives one byte per cycle unless rsp_stall is high.
// Three conversion stages run ahead, so readings are taken while a frame drains.
// Synchronous active-high reset clears valids and both unit selects.
// Depends on tfb_pkg and telemetry_frame_builder_core_defines.svh.
`default_nettype none
`include "telemetry_frame_builder_core_defines.svh"

module telemetry_frame_builder_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire tfb_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output tfb_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire tfb_pkg::csr_index_type  csr_index,
   input  wire logic                    csr_wdata
);

   typedef struct packed {
      logic [31:0]        seq;
      logic [31:0]        ts;
      logic [31:0]        hum;
      logic signed [15:0] temp;
      logic [16:0]        press;
      logic               neg;
      logic [18:0]        mag;
      logic [33:0]        num;
   } s1_type;

   typedef struct packed {
      logic [31:0]        seq;
      logic [31:0]        ts;
      logic [31:0]        hum;
      logic signed [15:0] temp;
      logic [16:0]        press;
      logic               neg;
      logic [38:0]        fifth_prod;
      logic [51:0]        pp_hi;
      logic [51:0]        pp_lo;
   } s2_type;

   typedef struct packed {
      logic [31:0]        seq;
      logic [31:0]        ts;
      logic [31:0]        hum;
      logic signed [15:0] temp;
      logic [16:0]        press;
      logic [31:0]        temp_f;
      logic [12:0]        inhg;
   } s3_type;

   logic temp_f_ff, temp_f_in;
   logic press_inhg_ff, press_inhg_in;

   logic   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   logic         ser_valid_ff, ser_valid_in;
   logic [4:0]   pos_ff, pos_in;
   logic [191:0] shift_ff, shift_in;

   logic ready1, ready2, ready3, ser_ready, ser_load, rsp_take, at_last;

   logic signed [19:0] t_ext;
   logic signed [19:0] x9;
   logic [16:0]        q5;
   logic [68:0]        inhg_sum;
   logic [31:0]        temp_word;
   logic [31:0]        press_word;
   logic [7:0]         units;
   logic [183:0]       body;
   logic [22:0]        column;
   logic [7:0]         check;
   logic [191:0]       frame;

   // Handshake: a stage loads when it is empty or its word moves on.
   always_comb begin
      rsp_take  = ser_valid_ff && !rsp_stall;
      at_last   = (pos_ff == tfb_pkg::LastPos);
      ser_ready = !ser_valid_ff || (rsp_take && at_last);
      ready3    = !v3_ff || ser_ready;
      ready2    = !v2_ff || ready3;
      ready1    = !v1_ff || ready2;
      ser_load  = v3_ff && ser_ready;
      req_stall = !ready1;
      v1_in     = ready1 ? req_valid : v1_ff;
      v2_in     = ready2 ? v1_ff : v2_ff;
      v3_in     = ready3 ? v2_ff : v3_ff;
   end

   always_comb begin
      temp_f_in     = temp_f_ff;
      press_inhg_in = press_inhg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tfb_pkg::REG_TEMP_F:     temp_f_in     = csr_wdata;
            tfb_pkg::REG_PRESS_INHG: press_inhg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: times nine with rounding bias, and the scaled pressure numerator.
   always_comb begin
      t_ext = 20'(req_data.temperature_c100);
      x9    = (t_ext <<< 3) + t_ext;
      s1_in.seq   = req_data.sequence_number;
      s1_in.ts    = req_data.timestamp;
      s1_in.hum   = req_data.humidity;
      s1_in.temp  = req_data.temperature_c100;
      s1_in.press = req_data.pressure_pa;
      s1_in.neg   = x9[19];
      s1_in.mag   = x9[19] ? 19'(20'sd2 - x9) : 19'(x9 + 20'sd2);
      s1_in.num   = 34'(req_data.pressure_pa) * tfb_pkg::PaScale + tfb_pkg::InhgBias;
   end

   // Stage 2: reciprocal products; the numerator is split in two halves.
   always_comb begin
      s2_in.seq        = s1_ff.seq;
      s2_in.ts         = s1_ff.ts;
      s2_in.hum        = s1_ff.hum;
      s2_in.temp       = s1_ff.temp;
      s2_in.press      = s1_ff.press;
      s2_in.neg        = s1_ff.neg;
      s2_in.fifth_prod = 39'(s1_ff.mag) * 39'(tfb_pkg::FifthRecip);
      s2_in.pp_hi      = 52'(s1_ff.num[33:17]) * 52'(tfb_pkg::InhgRecip);
      s2_in.pp_lo      = 52'(s1_ff.num[16:0]) * 52'(tfb_pkg::InhgRecip);
   end

   // Stage 3: quotients, signed offset for Fahrenheit.
   always_comb begin
      q5       = s2_ff.fifth_prod[38:tfb_pkg::FifthShift];
      inhg_sum = {s2_ff.pp_hi, 17'b0} + 69'(s2_ff.pp_lo);
      s3_in.seq    = s2_ff.seq;
      s3_in.ts     = s2_ff.ts;
      s3_in.hum    = s2_ff.hum;
      s3_in.temp   = s2_ff.temp;
      s3_in.press  = s2_ff.press;
      s3_in.temp_f = s2_ff.neg ? (tfb_pkg::FahrOffset - 32'(q5))
                               : (tfb_pkg::FahrOffset + 32'(q5));
      s3_in.inhg   = inhg_sum[68:tfb_pkg::InhgShift];
   end

   // Frame assembly at load time: byte 0 sits in the low bits.
   always_comb begin
      temp_word  = temp_f_ff ? s3_ff.temp_f : 32'(s3_ff.temp);
      press_word = press_inhg_ff ? 32'(s3_ff.inhg) : 32'(s3_ff.press);
      units      = (temp_f_ff ? tfb_pkg::UnitTempBit : 8'h00)
                 | (press_inhg_ff ? tfb_pkg::UnitPressBit : 8'h00);
      body  = {units, press_word, s3_ff.hum, temp_word, s3_ff.ts, s3_ff.seq,
               tfb_pkg::MagicB, tfb_pkg::MagicA};
      column = '0;
      for (int b = 0; b < 8; b++) begin
         for (int i = 0; i < 23; i++) begin
            column[i] = body[8 * i + b];
         end
         check[b] = ^column;
      end
      frame = {check, body};
   end

   always_comb begin
      ser_valid_in = ser_valid_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      if (ser_load) begin
         ser_valid_in = 1'b1;
         pos_in       = '0;
         shift_in     = frame;
      end else if (rsp_take) begin
         if (at_last) begin
            ser_valid_in = 1'b0;
         end else begin
            pos_in   = pos_ff + 5'd1;
            shift_in = shift_ff >> 8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_f_ff     <= 1'b0;
         press_inhg_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         ser_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         temp_f_ff     <= temp_f_in;
         press_inhg_ff <= press_inhg_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         ser_valid_ff  <= ser_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_ff <= s1_in;
      end
      if (ready2) begin
         s2_ff <= s2_in;
      end
      if (ready3) begin
         s3_ff <= s3_in;
      end
      shift_ff <= shift_in;
   end

   assign rsp_valid              = ser_valid_ff;
   assign rsp_data.frame_byte    = shift_ff[7:0];
   assign rsp_data.byte_position = pos_ff;
   assign rsp_data.last_byte     = at_last;

   `TFB_ASSERT_IMPL(a_stall_means_full, req_stall, v1_ff && v2_ff && v3_ff && ser_valid_ff)
   `TFB_ASSERT_NEXT(a_stage3_held, v3_ff && !ready3, v3_ff)
   `TFB_ASSERT_NEXT(a_pos_advance, rsp_take && !at_last, rsp_valid && (pos_ff == $past(pos_ff) + 5'd1))
   `TFB_ASSERT_IMPL(a_magic_first, ser_valid_ff && (pos_ff == 5'd0), shift_ff[7:0] == tfb_pkg::MagicA)
   `TFB_ASSERT_IMPL(a_pos_range, ser_valid_ff, pos_ff <= tfb_pkg::LastPos)

endmodule

`default_nettype wire
